>>> sv/fft_pkg.sv
`default_nettype none
package fft_pkg;
  localparam int Points = 64;
  localparam int Stages = 6;
  localparam int AddrW = 6;
  localparam int SampleW = 16;
  localparam int DataW = 22;
  localparam int WordW = 44;

  typedef enum logic [2:0] {
    ST_LOAD, ST_RD, ST_BF, ST_WR, ST_OUT_RD, ST_OUT
  } fft_state_e;

  localparam logic signed [16:0] QSIN [17] = '{
    17'sd0, 17'sd3212, 17'sd6393, 17'sd9512, 17'sd12539, 17'sd15446, 17'sd18204,
    17'sd20787, 17'sd23170, 17'sd25329, 17'sd27245, 17'sd28898, 17'sd30273,
    17'sd31356, 17'sd32137, 17'sd32609, 17'sd32767
  };

  function automatic logic signed [DataW-1:0] sat22(input logic signed [DataW+3:0] v);
    logic signed [DataW+3:0] hi, lo;
    hi = (DataW+4)'(2097151);
    lo = -(DataW+4)'(2097152);
    if (v > hi) return DataW'(hi);
    if (v < lo) return DataW'(lo);
    return DataW'(v);
  endfunction

  function automatic logic [AddrW-1:0] bitrev(input logic [AddrW-1:0] a);
    logic [AddrW-1:0] r;
    for (int b = 0; b < AddrW; b++) r[AddrW-1-b] = a[b];
    return r;
  endfunction
endpackage
`default_nettype wire

>>> sv/fft_ram.sv
`default_nettype none
module fft_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

>>> sv/radix2_fft_forward_inverse.sv
`default_nettype none
// After the last item of a block, the butterflies run stage by stage, 32 a stage. Each
// butterfly does two reads, a capture step and two writes; they share the single RAM
// port pair. The bins then leave in order: each is read from RAM in ST_OUT_RD, and
// its strobe is registered from ST_OUT. start is ignored while busy, so a new block
// is loaded only after the last bin is out.
// Reset clears control and mode; the work buffer is left unwritten. The
// receiver cannot stall: each bin is strobed for one cycle.
module radix2_fft_forward_inverse (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [fft_pkg::SampleW-1:0]  sample_re_i,
  input  wire logic signed [fft_pkg::SampleW-1:0]  sample_im_i,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic                                cfg_data_i,
  output logic                                     bin_valid_o,
  output logic signed [fft_pkg::DataW-1:0]         bin_re_o,
  output logic signed [fft_pkg::DataW-1:0]         bin_im_o,
  output logic                                     last_bin_o
);
  import fft_pkg::*;

  fft_state_e state_q, state_d;
  logic [AddrW-1:0] cnt_q, cnt_d;       // load count or bin index
  logic [2:0] stg_q, stg_d;             // stage, 0..5
  logic [AddrW-2:0] bf_q, bf_d;         // butterfly index inside stage
  logic ph_q, ph_d;                     // sub phase of read or write
  logic inv_q, run_inv_q;
  logic signed [DataW-1:0] ar_q, ai_q, br_q, bi_q;
  logic signed [DataW-1:0] pr, pi, mr, mi;

  logic we;
  logic [AddrW-1:0] waddr, raddr, addr_a, addr_b;
  logic [WordW-1:0] wdata, rdata;

  fft_ram #(.Width(WordW), .Depth(Points)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) inv_q <= 1'b0;
    else if (cfg_valid_i) inv_q <= cfg_data_i;
  end

  // Butterfly addresses: group of len = 2^(stg+1), k = low stg bits of bf.
  logic [AddrW-1:0] bfx, kmask, half, kk, tw_e;
  always_comb begin
    bfx   = {1'b0, bf_q};
    half  = AddrW'(1) << stg_q;
    kmask = half - AddrW'(1);
    kk    = bfx & kmask;
    addr_a = ((bfx & ~kmask) << 1) | kk;
    addr_b = addr_a | half;
    tw_e  = AddrW'(kk << (3'd5 - stg_q));
  end

  // Twiddle
  logic signed [16:0] wr, wi;
  always_comb begin
    logic [4:0] e;
    e = tw_e[4:0];
    if (e <= 5'd16) begin
      wr = QSIN[16 - e];
      wi = -QSIN[e];
    end else begin
      wr = -QSIN[e - 16];
      wi = -QSIN[32 - e];
    end
  end

  // Loaded sample; conjugation in inverse mode is done when the first stage reads it
  logic signed [DataW-1:0] ld_re, ld_im;
  assign ld_re = DataW'(sample_re_i);
  assign ld_im = DataW'(sample_im_i);

  // Complex multiply; products are rounded combinationally from the captured b and twiddle
  logic signed [DataW+17:0] m_rr, m_ii, m_ri, m_ir;
  logic signed [DataW+3:0] tr, ti;
  always_comb begin
    logic signed [DataW+18:0] sr, si;
    m_rr = br_q * wr;
    m_ii = bi_q * wi;
    m_ri = bi_q * wr;
    m_ir = br_q * wi;
    sr = (DataW+19)'(m_rr) - (DataW+19)'(m_ii) + (DataW+19)'(16384);
    si = (DataW+19)'(m_ri) + (DataW+19)'(m_ir) + (DataW+19)'(16384);
    tr = (DataW+4)'(sr >>> 15);
    ti = (DataW+4)'(si >>> 15);
  end

  // Butterfly sum and difference; a and b hold steady through both writes.
  assign pr = sat22((DataW+4)'(ar_q) + tr);
  assign pi = sat22((DataW+4)'(ai_q) + ti);
  assign mr = sat22((DataW+4)'(ar_q) - tr);
  assign mi = sat22((DataW+4)'(ai_q) - ti);

  // Read data unpack; on the first stage in inverse mode, apply conjugation
  logic signed [DataW-1:0] rd_re, rd_im;
  assign rd_re = rdata[DataW-1:0];
  assign rd_im = (stg_q == 3'd0 && run_inv_q)
      ? sat22(-(DataW+4)'(signed'(rdata[WordW-1:DataW])))
      : signed'(rdata[WordW-1:DataW]);

  // Every stage reads and writes back in place at the bit-reversed spots of its
  // butterfly pair.
  logic [AddrW-1:0] wra, wrb;
  assign wra = bitrev(addr_a);
  assign wrb = bitrev(addr_b);

  // Output scaling
  logic signed [DataW-1:0] o_re, o_im;
  always_comb begin
    logic signed [DataW+3:0] r, m;
    r = (DataW+4)'(rd_re);
    m = (DataW+4)'(signed'(rdata[WordW-1:DataW]));
    if (run_inv_q) begin
      r = (r + (DataW+4)'(Points/2)) >>> Stages;
      m = (-m + (DataW+4)'(Points/2)) >>> Stages;
    end
    o_re = sat22(r);
    o_im = sat22(m);
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    stg_d = stg_q;
    bf_d = bf_q;
    ph_d = ph_q;
    case (state_q)
      ST_LOAD: begin
        if (start) begin
          cnt_d = cnt_q + AddrW'(1);
          if (cnt_q == AddrW'(Points-1)) begin
            state_d = ST_RD;
            ph_d = 1'b0;
            stg_d = '0;
            bf_d = '0;
          end
        end
      end
      ST_RD: begin
        ph_d = ~ph_q;
        if (ph_q) state_d = ST_BF;
      end
      ST_BF: begin
        state_d = ST_WR;
        ph_d = 1'b0;
      end
      ST_WR: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          state_d = ST_RD;
          bf_d = bf_q + 1'b1;
          if (bf_q == '1) begin
            if (stg_q == 3'(Stages-1)) begin
              state_d = ST_OUT_RD;
              cnt_d = '0;
            end else begin
              stg_d = stg_q + 3'd1;
            end
          end
        end
      end
      ST_OUT_RD: state_d = ST_OUT;
      ST_OUT: begin
        cnt_d = cnt_q + AddrW'(1);
        state_d = (cnt_q == AddrW'(Points-1)) ? ST_LOAD : ST_OUT_RD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // All butterfly stages work in bit-reversed address space: logical index x
  // lives at RAM entry rev(x). Loaded entry i sits at rev(i) logically.
  // Bin x is then at RAM entry rev(x).
  always_comb begin
    we = 1'b0;
    waddr = cnt_q;
    wdata = {ld_im, ld_re};
    raddr = wra;
    busy = (state_q != ST_LOAD);
    case (state_q)
      ST_LOAD: we = start;
      ST_RD: raddr = ph_q ? wrb : wra;
      ST_WR: begin
        we = 1'b1;
        waddr = ph_q ? wrb : wra;
        wdata = ph_q ? {mi, mr} : {pi, pr};
      end
      ST_OUT_RD: raddr = bitrev(cnt_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    // RAM data of read a lands during the second read cycle.
    if (state_q == ST_RD && ph_q) begin
      ar_q <= rd_re;
      ai_q <= rd_im;
    end
    if (state_q == ST_BF) begin
      br_q <= rd_re;
      bi_q <= rd_im;
    end
    bin_re_o <= o_re;
    bin_im_o <= o_im;
    last_bin_o <= (cnt_q == AddrW'(Points-1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q <= '0;
      stg_q <= '0;
      bf_q <= '0;
      ph_q <= 1'b0;
      run_inv_q <= 1'b0;
      bin_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      stg_q <= stg_d;
      bf_q <= bf_d;
      ph_q <= ph_d;
      bin_valid_o <= (state_q == ST_OUT);
      if (state_q == ST_LOAD && start && cnt_q == AddrW'(Points-1)) run_inv_q <= inv_q;
    end
  end
endmodule
`default_nettype wire

>>> sv/fft_chk.sv
`default_nettype none
module fft_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic bin_valid_o,
  input wire logic last_bin_o
);
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_bin_o && bin_valid_o |=> !bin_valid_o) else $error("bin after last");
  a_no_bin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !$past(busy) |-> !bin_valid_o) else $error("bin while loading");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_valid_o |=> !bin_valid_o) else $error("back to back bins");
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start)) else $error("busy without an item");
endmodule
bind radix2_fft_forward_inverse fft_chk u_chk (.*);
`default_nettype wire
